/* rtl/mexp_pkg.sv */
`default_nettype none

package mexp_pkg;

   // default operand width
   localparam int VALUE_WIDTH_DEFAULT = 16;

   // register index codes on the csr channel
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_GO,
      ST_BASE_WAIT,
      ST_SQUARE_GO,
      ST_SQUARE_WAIT,
      ST_MULTIPLY_GO,
      ST_MULTIPLY_WAIT,
      ST_FINISH
   } mexp_state_type;

   // operand pairing for the shared modular multiplier
   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_SQUARE,
      OP_MULTIPLY
   } mexp_op_type;

   typedef struct packed {
      logic        load;
      logic        start;
      mexp_op_type op_sel;
      logic        write_base;
      logic        write_acc;
      logic        advance;
      logic        load_result;
   } mexp_cmd_type;

   typedef struct packed {
      logic small_modulus;
      logic mul_done;
      logic exp_msb;
      logic out_free;
   } mexp_status_type;

endpackage

`default_nettype wire

/* rtl/mexp_mulmod.sv */
`default_nettype none

// interleaved modular multiply, one multiplier bit per cycle
module mexp_mulmod #(
   parameter int VALUE_WIDTH = mexp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] multiplicand,
   input  wire logic [VALUE_WIDTH-1:0] multiplier,
   input  wire logic [VALUE_WIDTH-1:0] modulus,
   output logic                        done,
   output logic [VALUE_WIDTH-1:0]      product
);

   localparam int CW = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [VALUE_WIDTH-1:0] m_ff, m_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;

   logic [VALUE_WIDTH+1:0] sum;
   logic [VALUE_WIDTH+1:0] once_m;
   logic [VALUE_WIDTH+1:0] twice_m;
   logic [VALUE_WIDTH+1:0] reduced_wide;
   logic [VALUE_WIDTH-1:0] reduced;

   // 2*acc + bit*a stays below 3*m, so at most one of m or 2m comes off
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (b_ff[VALUE_WIDTH-1] ? {2'b00, a_ff} : '0);
      once_m = {2'b00, m_ff};
      twice_m = {1'b0, m_ff, 1'b0};
      priority if (sum >= twice_m) begin
         reduced_wide = sum - twice_m;
      end else if (sum >= once_m) begin
         reduced_wide = sum - once_m;
      end else begin
         reduced_wide = sum;
      end
      reduced = reduced_wide[VALUE_WIDTH-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_WIDTH - 1);
         a_in    = multiplicand;
         b_in    = multiplier;
         m_in    = modulus;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = reduced;
         b_in   = {b_ff[VALUE_WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("multiplier not busy after start");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("done without a finished run");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> (done_ff && !busy_ff))
      else $error("last step did not raise done");

endmodule

`default_nettype wire

/* rtl/mexp_ctrl.sv */
`default_nettype none

module mexp_ctrl #(
   parameter int VALUE_WIDTH = mexp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire mexp_pkg::mexp_status_type status,
   output mexp_pkg::mexp_cmd_type       cmd
);

   localparam int CW = $clog2(VALUE_WIDTH);

   mexp_pkg::mexp_state_type state_ff, state_in;
   logic [CW-1:0]            bit_cnt_ff, bit_cnt_in;
   logic                     last_bit;

   assign last_bit = (bit_cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.small_modulus ? mexp_pkg::ST_FINISH
                                               : mexp_pkg::ST_BASE_GO;
            end
         end
         mexp_pkg::ST_BASE_GO: state_in = mexp_pkg::ST_BASE_WAIT;
         mexp_pkg::ST_BASE_WAIT: begin
            if (status.mul_done) state_in = mexp_pkg::ST_SQUARE_GO;
         end
         mexp_pkg::ST_SQUARE_GO: state_in = mexp_pkg::ST_SQUARE_WAIT;
         mexp_pkg::ST_SQUARE_WAIT: begin
            if (status.mul_done) begin
               priority if (status.exp_msb) state_in = mexp_pkg::ST_MULTIPLY_GO;
               else if (last_bit)           state_in = mexp_pkg::ST_FINISH;
               else                         state_in = mexp_pkg::ST_SQUARE_GO;
            end
         end
         mexp_pkg::ST_MULTIPLY_GO: state_in = mexp_pkg::ST_MULTIPLY_WAIT;
         mexp_pkg::ST_MULTIPLY_WAIT: begin
            if (status.mul_done) begin
               state_in = last_bit ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQUARE_GO;
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (status.out_free) state_in = mexp_pkg::ST_IDLE;
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd.load        = 1'b0;
      cmd.start       = 1'b0;
      cmd.op_sel      = mexp_pkg::OP_REDUCE;
      cmd.write_base  = 1'b0;
      cmd.write_acc   = 1'b0;
      cmd.advance     = 1'b0;
      cmd.load_result = 1'b0;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         mexp_pkg::ST_BASE_GO: begin
            cmd.start  = 1'b1;
            cmd.op_sel = mexp_pkg::OP_REDUCE;
         end
         mexp_pkg::ST_BASE_WAIT: cmd.write_base = status.mul_done;
         mexp_pkg::ST_SQUARE_GO: begin
            cmd.start  = 1'b1;
            cmd.op_sel = mexp_pkg::OP_SQUARE;
         end
         mexp_pkg::ST_SQUARE_WAIT: begin
            cmd.write_acc = status.mul_done;
            cmd.advance   = status.mul_done && !status.exp_msb;
         end
         mexp_pkg::ST_MULTIPLY_GO: begin
            cmd.start  = 1'b1;
            cmd.op_sel = mexp_pkg::OP_MULTIPLY;
         end
         mexp_pkg::ST_MULTIPLY_WAIT: begin
            cmd.write_acc = status.mul_done;
            cmd.advance   = status.mul_done;
         end
         mexp_pkg::ST_FINISH: cmd.load_result = status.out_free;
         default: ;
      endcase
   end

   always_comb begin
      priority if (cmd.load) bit_cnt_in = CW'(VALUE_WIDTH - 1);
      else if (cmd.advance)  bit_cnt_in = bit_cnt_ff - 1'b1;
      else                   bit_cnt_in = bit_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mexp_pkg::ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mexp_datapath.sv */
`default_nettype none

module mexp_datapath #(
   parameter int VALUE_WIDTH = mexp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mexp_pkg::mexp_cmd_type cmd,
   output mexp_pkg::mexp_status_type   status,
   input  wire logic [VALUE_WIDTH-1:0] req_message_value,
   input  wire logic [VALUE_WIDTH-1:0] exponent,
   input  wire logic [VALUE_WIDTH-1:0] modulus,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0]      rsp_power_result
);

   logic [VALUE_WIDTH-1:0] msg_ff, msg_in;
   logic [VALUE_WIDTH-1:0] exp_ff, exp_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [VALUE_WIDTH-1:0] mul_a;
   logic [VALUE_WIDTH-1:0] mul_b;
   logic                   mul_done;
   logic [VALUE_WIDTH-1:0] mul_product;
   logic                   small_modulus;
   logic                   out_free;

   assign small_modulus = (modulus[VALUE_WIDTH-1:1] == '0);
   assign out_free      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.op_sel)
         mexp_pkg::OP_REDUCE: begin
            mul_a = VALUE_WIDTH'(1);
            mul_b = msg_ff;
         end
         mexp_pkg::OP_SQUARE: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
         mexp_pkg::OP_MULTIPLY: begin
            mul_a = base_ff;
            mul_b = acc_ff;
         end
         default: begin
            mul_a = VALUE_WIDTH'(1);
            mul_b = msg_ff;
         end
      endcase
   end

   mexp_mulmod #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_mulmod (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.start),
      .multiplicand(mul_a),
      .multiplier  (mul_b),
      .modulus     (modulus),
      .done        (mul_done),
      .product     (mul_product)
   );

   always_comb begin
      msg_in = cmd.load ? req_message_value : msg_ff;

      priority if (cmd.load) exp_in = exponent;
      else if (cmd.advance)  exp_in = {exp_ff[VALUE_WIDTH-2:0], 1'b0};
      else                   exp_in = exp_ff;

      // no modular answer below modulus two, result is zero
      priority if (cmd.load)    acc_in = small_modulus ? '0 : VALUE_WIDTH'(1);
      else if (cmd.write_acc)   acc_in = mul_product;
      else                      acc_in = acc_ff;

      base_in = cmd.write_base ? mul_product : base_ff;

      priority if (cmd.load_result) rsp_valid_in = 1'b1;
      else if (rsp_ready)           rsp_valid_in = 1'b0;
      else                          rsp_valid_in = rsp_valid_ff;

      rsp_data_in = cmd.load_result ? acc_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff      <= msg_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.small_modulus = small_modulus;
   assign status.mul_done      = mul_done;
   assign status.exp_msb       = exp_ff[VALUE_WIDTH-1];
   assign status.out_free      = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/modular_exponentiation.sv */
`default_nettype none

// modular exponentiation engine: each req transaction carries a value m and
// returns one rsp transaction with m to the power of the exponent register,
// reduced mod the modulus register (csr index 0 is the exponent, index 1 the
// modulus, other indexes are ignored; reset gives exponent 0 and modulus 2).
// an exponent of zero gives 1, a modulus of zero or one gives 0. the engine
// works on one transaction at a time with square-and-multiply from the top
// exponent bit down, all through one shared bit-serial modular multiplier;
// with a modulus below two it skips the multiplier and goes straight to the
// result. a finished result sits in an output register, so the next req
// transaction can be taken while the previous rsp still waits. write csr
// registers only while the engine is idle.
module modular_exponentiation #(
   parameter int VALUE_WIDTH = mexp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input transactions
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [VALUE_WIDTH-1:0]               req_message_value,
   // result transactions
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [VALUE_WIDTH-1:0]                    rsp_power_result,
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [VALUE_WIDTH-1:0]               csr_data
);

   // configuration registers
   logic [VALUE_WIDTH-1:0] exponent_ff, exponent_in;
   logic [VALUE_WIDTH-1:0] modulus_ff, modulus_in;

   // controller to datapath
   mexp_pkg::mexp_cmd_type    cmd;
   mexp_pkg::mexp_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mexp_pkg::CSR_EXPONENT: exponent_in = csr_data;
            mexp_pkg::CSR_MODULUS:  modulus_in  = csr_data;
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= '0;
         modulus_ff  <= VALUE_WIDTH'(2);
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   // sequencer: operand reduction, then square and optional multiply per bit
   mexp_ctrl #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // operand registers, shared multiplier and output register
   mexp_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_message_value(req_message_value),
      .exponent         (exponent_ff),
      .modulus          (modulus_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_power_result (rsp_power_result)
   );

endmodule

`default_nettype wire

/* tb/sv/modular_exponentiation_tb.sv */
`timescale 1ns / 1ps

module modular_exponentiation_tb;

   localparam int VW              = mexp_pkg::VALUE_WIDTH_DEFAULT;
   localparam int CLOCK_PERIOD    = 4;
   localparam int RESET_CYCLES    = 12;
   // the limit lies several times over the longest receiver hold-off,
   // HOLD_OFF_CYCLES, and over any one transaction
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int HOLD_OFF_CYCLES = 2500;
   localparam int SETTLE_CYCLES   = 2;
   localparam int DRAIN_CYCLES    = 700;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 82;
   localparam int PRESSURE_PHASE  = 3;
   localparam int QUIET_PHASES    = 3;

   // indexes past the register list, writes to them must leave both alone
   localparam logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW  = 2'd2;
   localparam logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HIGH = 2'd3;

   typedef logic [VW-1:0] value_type;

   // expected power results in arrival order, plus shadow copies of the
   // exponent and modulus registers
   class power_scoreboard;
      value_type pending_powers[$];
      value_type exponent_shadow;
      value_type modulus_shadow;
      int        mismatches;
      int        noted;
      int        checked;

      function new();
         exponent_shadow = '0;
         modulus_shadow  = value_type'(2);
         mismatches      = 0;
         noted           = 0;
         checked         = 0;
      endfunction

      function void write_register(logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] index,
                                   value_type data);
         case (index)
            mexp_pkg::CSR_EXPONENT: exponent_shadow = data;
            mexp_pkg::CSR_MODULUS:  modulus_shadow  = data;
            default: ;
         endcase
      endfunction

      // square-and-multiply from the top exponent bit, products at twice the width
      function value_type modular_power(value_type message);
         logic [2*VW-1:0] acc;
         logic [2*VW-1:0] base;
         logic [2*VW-1:0] n;
         int              bit_pos;
         if (modulus_shadow < 2)
            return '0;
         n    = {{VW{1'b0}}, modulus_shadow};
         base = {{VW{1'b0}}, message} % n;
         acc  = 1 % n;
         for (bit_pos = VW - 1; bit_pos >= 0; bit_pos--) begin
            acc = (acc * acc) % n;
            if (exponent_shadow[bit_pos])
               acc = (acc * base) % n;
         end
         return acc[VW-1:0];
      endfunction

      function void note_message(value_type message);
         pending_powers.push_back(modular_power(message));
         noted++;
      endfunction

      function void check_result(value_type actual);
         value_type expected;
         if (pending_powers.size() == 0) begin
            $display("%0t: power_result %0d arrived with nothing expected", $time, actual);
            mismatches++;
            return;
         end
         expected = pending_powers.pop_front();
         checked++;
         if (actual !== expected) begin
            $display("%0t: power_result mismatch, expected %0d, actual %0d",
                     $time, expected, actual);
            mismatches++;
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   value_type req_message_value;
   logic      rsp_valid;
   logic      rsp_ready;
   value_type rsp_power_result;
   logic      csr_valid;
   logic      csr_ready;
   logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   value_type csr_data;

   power_scoreboard sb;
   bit  idle_enabled     = 1'b1;
   bit  hold_off_request = 1'b0;
   int  quiet_cycles     = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   modular_exponentiation #(
      .VALUE_WIDTH(VW)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_value(req_message_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_power_result (rsp_power_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // all transactions are seen here at the rising edge; a message is noted
   // before any result of the same edge is checked, though a result can never
   // belong to a message accepted at that very edge
   always @(posedge clock) begin
      if (req_valid && req_ready)
         sb.note_message(req_message_value);
      if (rsp_valid && rsp_ready)
         sb.check_result(rsp_power_result);
      if (csr_valid && csr_ready)
         sb.write_register(csr_index, csr_data);
      // watchdog: cycles with no transaction on any channel
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request so
   // the output register fills and the engine stops taking messages
   initial begin
      int stall_cycles;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (hold_off_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            stall_cycles = $urandom_range(1, 11);
            rsp_ready = 1'b0;
            repeat (stall_cycles - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // offers one message, entered and left at a falling edge; valid stays up
   // between back-to-back messages
   task automatic send_message(input value_type message);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_message_value = message;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_register_port(input logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] index,
                                      input value_type data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // every message gives a result, so an empty queue means the engine is idle
   task automatic wait_until_idle();
      req_valid = 1'b0;
      while (sb.pending_powers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input value_type exponent_value, input value_type modulus_value);
      wait_until_idle();
      write_register_port(mexp_pkg::CSR_EXPONENT, exponent_value);
      write_register_port(mexp_pkg::CSR_MODULUS, modulus_value);
   endtask

   initial begin
      int        phase;
      int        item;
      int        settings_used;
      value_type exponent_value;
      value_type modulus_value;
      value_type message;

      sb                = new();
      settings_used     = 1;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_message_value = '0;
      csr_valid         = 1'b0;
      csr_index         = mexp_pkg::CSR_EXPONENT;
      csr_data          = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset registers: exponent 0, modulus 2
      send_message('0);
      send_message(value_type'(1));
      send_message('1);

      // exponent zero with the largest modulus gives 1 for every message
      configure('0, '1);
      send_message('0);
      send_message('1);

      // full exponent, messages at and just below the modulus
      configure('1, '1);
      send_message('1);
      send_message(value_type'(65534));

      // full exponent with a prime modulus
      configure('1, value_type'(65521));
      send_message(value_type'(2));

      // modulus zero and one have no modular answer
      configure(value_type'(5), '0);
      send_message(value_type'(7));
      send_message('1);
      configure(value_type'(5), value_type'(1));
      send_message(value_type'(7));

      // exponent one with the smallest modulus: plain reduction
      configure(value_type'(1), value_type'(2));
      send_message(value_type'(12345));
      send_message('1);

      // textbook key pair, n = 61 * 53: encrypt, then decrypt
      configure(value_type'(17), value_type'(3233));
      send_message(value_type'(65));
      send_message(value_type'(3232));
      send_message(value_type'(5000));
      configure(value_type'(2753), value_type'(3233));
      send_message(value_type'(2790));
      send_message(value_type'(1));

      // writes past the register list must change nothing
      wait_until_idle();
      write_register_port(CSR_UNUSED_LOW, '0);
      write_register_port(CSR_UNUSED_HIGH, value_type'(1));
      send_message(value_type'(2790));
      send_message(value_type'(65));
      settings_used += 8;

      // random settings, the extremes picked often
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       exponent_value = '0;
            1:       exponent_value = '1;
            2:       exponent_value = value_type'(1);
            3:       exponent_value = value_type'($urandom_range(2, 31));
            default: exponent_value = value_type'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       modulus_value = '1;
            1:       modulus_value = value_type'(2);
            2:       modulus_value = value_type'($urandom_range(0, 1));
            3:       modulus_value = value_type'($urandom_range(3, 255));
            default: modulus_value = value_type'($urandom_range(2, 65535));
         endcase
         // last part of the run goes without any idling
         if (phase >= RANDOM_PHASES - QUIET_PHASES)
            idle_enabled = 1'b0;
         configure(exponent_value, modulus_value);
         if ($urandom_range(0, 2) == 0)
            write_register_port($urandom_range(0, 1) ? CSR_UNUSED_LOW : CSR_UNUSED_HIGH,
                                value_type'($urandom));
         settings_used++;
         if (phase == PRESSURE_PHASE)
            hold_off_request = 1'b1;
         for (item = 0; item < PHASE_ITEMS; item++) begin
            case ($urandom_range(0, 7))
               0:       message = '0;
               1:       message = '1;
               2:       message = (modulus_value > 1) ?
                                  value_type'($urandom_range(0, modulus_value - 1)) :
                                  value_type'($urandom);
               default: message = value_type'($urandom);
            endcase
            send_message(message);
         end
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d messages through %0d register settings, %0d results compared",
               sb.noted, settings_used, sb.checked);
      $display("covered zero and full exponents, moduli 0 to 65535, unused indexes, long stall");
      if (sb.mismatches == 0 && sb.pending_powers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_ctrl.sv
rtl/mexp_datapath.sv
rtl/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
